FILE: hdl/snfcs_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// snfcs_pkg
// shared types, constants and the opcode function of the flash command sequencer
// ----------------------------------------------------------------------------
package snfcs_pkg;

    localparam logic [3:0] OP_READ   = 4'd0;
    localparam logic [3:0] OP_FREAD  = 4'd1;
    localparam logic [3:0] OP_PROG   = 4'd2;
    localparam logic [3:0] OP_SERASE = 4'd3;
    localparam logic [3:0] OP_CERASE = 4'd4;
    localparam logic [3:0] OP_WREN   = 4'd5;
    localparam logic [3:0] OP_WRDIS  = 4'd6;
    localparam logic [3:0] OP_RDSR   = 4'd7;
    localparam logic [3:0] OP_WRSR   = 4'd8;
    localparam logic [3:0] OP_ID     = 4'd9;
    localparam logic [3:0] OP_UID    = 4'd10;
    localparam logic [3:0] OP_PD     = 4'd11;
    localparam logic [3:0] OP_WAKE   = 4'd12;

    localparam logic [0:0] CMD_START  = 1'b0;
    localparam logic [0:0] CMD_REPORT = 1'b1;

    typedef struct packed {
        logic [0:0]  cmd;
        logic [3:0]  op;
        logic [23:0] address;
        logic [15:0] length;
        logic [7:0]  write_byte;
        logic [7:0]  rx_byte;
    } req_t;

    typedef struct packed {
        logic [7:0] mosi_byte;
        logic       byte_valid;
        logic       new_frame;
        logic       data_taken;
        logic       read_valid;
        logic [7:0] read_data;
        logic       done_res;
        logic       error;
    } res_t;

    function automatic logic [7:0] opcode(input logic [3:0] op);
        logic [7:0] r;
        begin
            case (op)
                OP_READ:   r = 8'h03;
                OP_FREAD:  r = 8'h0B;
                OP_PROG:   r = 8'h02;
                OP_SERASE: r = 8'h20;
                OP_CERASE: r = 8'hC7;
                OP_WREN:   r = 8'h06;
                OP_WRDIS:  r = 8'h04;
                OP_RDSR:   r = 8'h05;
                OP_WRSR:   r = 8'h01;
                OP_ID:     r = 8'h90;
                OP_UID:    r = 8'h4B;
                OP_PD:     r = 8'hB9;
                OP_WAKE:   r = 8'hAB;
                default:   r = 8'h03;
            endcase
            return r;
        end
    endfunction

endpackage
`default_nettype wire

FILE: hdl/snfcs_fifo.sv
`default_nettype none
// ----------------------------------------------------------------------------
// snfcs_fifo
// two-entry queue used between the front, the engine and the result port
// ----------------------------------------------------------------------------
module snfcs_fifo #(
    parameter int WIDTH = 8
) (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             push,
    input  wire logic [WIDTH-1:0] push_data,
    output logic                  full,
    input  wire logic             pop,
    output logic [WIDTH-1:0]      pop_data,
    output logic                  empty
);
    logic [WIDTH-1:0] mem_reg [2];
    logic             wptr_reg, rptr_reg;
    logic [1:0]       count_reg;
    logic             do_push, do_pop;

    assign full     = (count_reg == 2'd2);
    assign empty    = (count_reg == 2'd0);
    assign do_push  = push && !full;
    assign do_pop   = pop && !empty;
    assign pop_data = mem_reg[rptr_reg];

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem_reg[wptr_reg] <= push_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wptr_reg  <= 1'b0;
            rptr_reg  <= 1'b0;
            count_reg <= 2'd0;
        end
        else
        begin
            if (do_push)
            begin
                wptr_reg <= ~wptr_reg;
            end
            if (do_pop)
            begin
                rptr_reg <= ~rptr_reg;
            end
            count_reg <= count_reg + {1'b0, do_push} - {1'b0, do_pop};
        end
    end
endmodule
`default_nettype wire

FILE: hdl/snfcs_engine.sv
`default_nettype none
// ----------------------------------------------------------------------------
// snfcs_engine
// phase sequencer: while the result queue is not full, one request in, one result out per cycle
// ----------------------------------------------------------------------------
module snfcs_engine import snfcs_pkg::*; #(
    parameter int PAGE_BYTES   = 256,
    parameter int SECTOR_BYTES = 4096
) (
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic req_valid,
    input  wire req_t req,
    output logic      req_ready,
    output logic      res_valid,
    output res_t      res,
    input  wire logic res_full
);
    localparam int PW = $clog2(PAGE_BYTES);
    localparam int SW = $clog2(SECTOR_BYTES);
    localparam int CW = PW + 1;

    localparam logic [2:0] PH_IDLE     = 3'd0;
    localparam logic [2:0] PH_WREN     = 3'd1;
    localparam logic [2:0] PH_PRE_CMD  = 3'd2;
    localparam logic [2:0] PH_PRE_RD   = 3'd3;
    localparam logic [2:0] PH_MAIN     = 3'd4;
    localparam logic [2:0] PH_DATA     = 3'd5;
    localparam logic [2:0] PH_POST_CMD = 3'd6;
    localparam logic [2:0] PH_POST_RD  = 3'd7;

    logic [2:0]    phase_reg, phase_next;
    logic [3:0]    op_reg, op_next;
    logic [23:0]   addr_reg, addr_next;
    logic [15:0]   left_reg, left_next;
    logic [CW-1:0] chunk_reg, chunk_next;
    logic [2:0]    fidx_reg, fidx_next;
    logic          lwr_reg, lwr_next;
    res_t          r;
    logic          fire;
    logic [2:0]    hlen, fidx_inc;
    logic          has_pay;
    logic [7:0]    hbyte;
    logic [CW-1:0] room;
    logic [23:0]   saddr;

    assign req_ready = !res_full;
    assign fire      = req_valid && req_ready;
    assign res_valid = fire;
    assign res       = r;

    assign room  = CW'(PAGE_BYTES) - {1'b0, addr_reg[PW-1:0]};
    assign saddr = 24'({req.address, {SW{1'b0}}});
    assign fidx_inc = fidx_reg + 3'd1;
    assign has_pay = (op_reg == OP_PROG) ? (chunk_reg != '0) : (left_reg != '0);

    always_comb
    begin
        case (op_reg)
            OP_READ, OP_PROG, OP_SERASE, OP_ID: hlen = 3'd4;
            OP_FREAD, OP_UID:                   hlen = 3'd5;
            default:                            hlen = 3'd1;
        endcase
        if (op_reg <= OP_SERASE)
        begin
            case (fidx_inc)
                3'd1:    hbyte = addr_reg[23:16];
                3'd2:    hbyte = addr_reg[15:8];
                3'd3:    hbyte = addr_reg[7:0];
                default: hbyte = 8'hFF;
            endcase
        end
        else
        begin
            hbyte = 8'h00;
        end
    end

    always_comb
    begin
        phase_next = phase_reg;
        op_next    = op_reg;
        addr_next  = addr_reg;
        left_next  = left_reg;
        chunk_next = chunk_reg;
        fidx_next  = fidx_reg;
        lwr_next   = lwr_reg;
        r          = '0;
        if (req.cmd == CMD_START)
        begin
            if (phase_reg != PH_IDLE)
            begin
                r.error = 1'b1;
            end
            else
            begin
                op_next    = req.op;
                lwr_next   = 1'b0;
                fidx_next  = '0;
                chunk_next = '0;
                addr_next  = (req.op == OP_SERASE) ? saddr : req.address;
                case (req.op)
                    OP_READ, OP_FREAD, OP_PROG: left_next = req.length;
                    OP_RDSR, OP_WRSR:           left_next = 16'd1;
                    OP_ID:                      left_next = 16'd2;
                    OP_UID:                     left_next = 16'd8;
                    default:                    left_next = '0;
                endcase
                if (req.op > OP_WAKE || (req.op == OP_PROG && req.length == '0))
                begin
                    phase_next = PH_IDLE;
                    left_next  = '0;
                    r.done_res = 1'b1;
                end
                else if (req.op == OP_PROG || req.op == OP_SERASE || req.op == OP_CERASE)
                begin
                    if (req.op == OP_PROG)
                    begin
                        // first page chunk
                        if ({1'b0, req.length} < 17'(CW'(PAGE_BYTES)
                            - {1'b0, req.address[PW-1:0]}))
                            chunk_next = CW'(req.length);
                        else
                            chunk_next = CW'(PAGE_BYTES) - {1'b0, req.address[PW-1:0]};
                    end
                    phase_next   = PH_WREN;
                    r.mosi_byte  = 8'h06;
                    r.byte_valid = 1'b1;
                    r.new_frame  = 1'b1;
                end
                else
                begin
                    phase_next   = PH_MAIN;
                    r.mosi_byte  = opcode(req.op);
                    r.byte_valid = 1'b1;
                    r.new_frame  = 1'b1;
                end
            end
        end
        else if (phase_reg == PH_IDLE)
        begin
            r.error = 1'b1;
        end
        else
        begin
            r.read_valid = lwr_reg;
            r.read_data  = lwr_reg ? req.rx_byte : 8'h00;
            lwr_next     = 1'b0;
            r.byte_valid = 1'b1;
            case (phase_reg)
                PH_WREN:
                begin
                    r.new_frame = 1'b1;
                    if (op_reg == OP_PROG)
                    begin
                        phase_next  = PH_MAIN;
                        fidx_next   = '0;
                        r.mosi_byte = opcode(op_reg);
                    end
                    else
                    begin
                        phase_next  = PH_PRE_CMD;
                        r.mosi_byte = 8'h05;
                    end
                end
                PH_PRE_CMD, PH_POST_CMD:
                begin
                    phase_next  = phase_reg + 3'd1;
                    r.mosi_byte = 8'hFF;
                end
                PH_PRE_RD:
                begin
                    r.new_frame = 1'b1;
                    if (req.rx_byte[0])
                    begin
                        phase_next  = PH_PRE_CMD;
                        r.mosi_byte = 8'h05;
                    end
                    else
                    begin
                        phase_next  = PH_MAIN;
                        fidx_next   = '0;
                        r.mosi_byte = opcode(op_reg);
                    end
                end
                PH_POST_RD:
                begin
                    r.new_frame = 1'b1;
                    if (req.rx_byte[0])
                    begin
                        phase_next  = PH_POST_CMD;
                        r.mosi_byte = 8'h05;
                    end
                    else if (op_reg == OP_PROG && left_reg != '0)
                    begin
                        if ({{(CW > 16 ? 0 : 1){1'b0}}, left_reg} < 17'(room))
                            chunk_next = CW'(left_reg);
                        else
                            chunk_next = room;
                        phase_next  = PH_WREN;
                        r.mosi_byte = 8'h06;
                    end
                    else
                    begin
                        r = '0;
                        r.done_res = 1'b1;
                        phase_next = PH_IDLE;
                        fidx_next  = '0;
                        chunk_next = '0;
                        left_next  = '0;
                    end
                end
                default:
                begin
                    // main header or data
                    if (phase_reg == PH_MAIN)
                        fidx_next = fidx_inc;
                    if (phase_reg == PH_MAIN && fidx_inc < hlen)
                    begin
                        r.mosi_byte = hbyte;
                    end
                    else if (has_pay)
                    begin
                        phase_next = PH_DATA;
                        left_next  = left_reg - 16'd1;
                        if (op_reg == OP_PROG || op_reg == OP_WRSR)
                        begin
                            r.mosi_byte  = req.write_byte;
                            r.data_taken = 1'b1;
                            if (op_reg == OP_PROG)
                            begin
                                chunk_next = chunk_reg - CW'(1);
                                addr_next  = addr_reg + 24'd1;
                            end
                        end
                        else
                        begin
                            r.mosi_byte = 8'hFF;
                            lwr_next    = 1'b1;
                        end
                    end
                    else if (op_reg == OP_PROG || op_reg == OP_SERASE
                             || op_reg == OP_CERASE)
                    begin
                        phase_next  = PH_POST_CMD;
                        r.mosi_byte = 8'h05;
                        r.new_frame = 1'b1;
                    end
                    else
                    begin
                        r.byte_valid = 1'b0;
                        r.mosi_byte  = 8'h00;
                        r.done_res   = 1'b1;
                        phase_next   = PH_IDLE;
                        fidx_next    = '0;
                        chunk_next   = '0;
                        left_next    = '0;
                    end
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_IDLE;
            op_reg    <= '0;
            addr_reg  <= '0;
            left_reg  <= '0;
            chunk_reg <= '0;
            fidx_reg  <= '0;
            lwr_reg   <= 1'b0;
        end
        else if (fire)
        begin
            phase_reg <= phase_next;
            op_reg    <= op_next;
            addr_reg  <= addr_next;
            left_reg  <= left_next;
            chunk_reg <= chunk_next;
            fidx_reg  <= fidx_next;
            lwr_reg   <= lwr_next;
        end
    end
endmodule
`default_nettype wire

FILE: hdl/spi_nor_flash_command_sequencer_top.sv
`default_nettype none
// ----------------------------------------------------------------------------
// spi_nor_flash_command_sequencer_top
// turns host requests into spi nor flash byte frames, at most one byte per request
// ----------------------------------------------------------------------------
// path: a request's result is pushed into the result queue when the engine takes it from the input queue
// throughput: one request per cycle while the result queue is not full, set by the phase engine
// input queue and result queue are two entries deep each
// reset: asynchronous, active low; queues empty and the engine idle
module spi_nor_flash_command_sequencer_top import snfcs_pkg::*; #(
    parameter int PAGE_BYTES   = 256,
    parameter int SECTOR_BYTES = 4096
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        push,
    output logic             full,
    input  wire logic [0:0]  cmd,
    input  wire logic [3:0]  op,
    input  wire logic [23:0] address,
    input  wire logic [15:0] length,
    input  wire logic [7:0]  write_byte,
    input  wire logic [7:0]  rx_byte,
    output logic             empty,
    input  wire logic        pop,
    output logic [7:0]       mosi_byte,
    output logic             byte_valid,
    output logic             new_frame,
    output logic             data_taken,
    output logic             read_valid,
    output logic [7:0]       read_data,
    output logic             done_res,
    output logic             error
);
    req_t in_req, q_req;
    res_t e_res, out_res;
    logic q_empty, e_ready, e_valid, r_full;

    assign in_req = '{cmd: cmd, op: op, address: address, length: length,
                      write_byte: write_byte, rx_byte: rx_byte};

    snfcs_fifo #(.WIDTH($bits(req_t))) u_front (
        .clk(clk), .rst_n(rst_n),
        .push(push), .push_data(in_req), .full(full),
        .pop(e_ready), .pop_data(q_req), .empty(q_empty)
    );

    snfcs_engine #(.PAGE_BYTES(PAGE_BYTES), .SECTOR_BYTES(SECTOR_BYTES)) u_engine (
        .clk(clk), .rst_n(rst_n),
        .req_valid(!q_empty), .req(q_req), .req_ready(e_ready),
        .res_valid(e_valid), .res(e_res), .res_full(r_full)
    );

    snfcs_fifo #(.WIDTH($bits(res_t))) u_back (
        .clk(clk), .rst_n(rst_n),
        .push(e_valid), .push_data(e_res), .full(r_full),
        .pop(pop), .pop_data(out_res), .empty(empty)
    );

    assign mosi_byte  = out_res.mosi_byte;
    assign byte_valid = out_res.byte_valid;
    assign new_frame  = out_res.new_frame;
    assign data_taken = out_res.data_taken;
    assign read_valid = out_res.read_valid;
    assign read_data  = out_res.read_data;
    assign done_res   = out_res.done_res;
    assign error      = out_res.error;
endmodule
`default_nettype wire
